// ----- hdl/sps_pkg.sv -----
`timescale 1ns / 1ps

package sps_pkg;

  localparam int ALPHABET_DEF = 64;
  localparam int CODE_W       = 6;
  localparam int VALUE_W      = 16;
  localparam int SUM_W        = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PAIR = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
    logic ok;
  } lookup_t;

endpackage

// ----- hdl/substitution_penalty_sum.sv -----
`timescale 1ns / 1ps
// Substitution penalty accumulator.
// Input stream: in_tuser selects the request kind (load a table entry or
// look up a feature pair), in_tlast marks the final pair of a record pair.
// Load requests write the penalty for (code_a, code_b); pair requests read it
// and add it to a running sum that saturates at the signed 32-bit limits.
// Output stream: one pair_distance per pair request with in_tlast set.
// Throughput: one request per cycle while in_tready is high, loads and pairs mixed
// freely; the rate is set by the single table read port and the add-and-clamp loop.
// Result path: a last pair passes the table read register, then the sum and output
// register, before its result is valid.
// Reset: clears the running sum and empties the pipeline; table contents are
// undefined and every entry must be loaded before it is looked up.
// Stall: while a result waits in the output register with out_tready low, pairs
// without the last mark keep flowing; a last pair waits in the lookup stage and
// in_tready drops until the output register is taken.
module substitution_penalty_sum #(
  parameter int ALPHABET = sps_pkg::ALPHABET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // code_a[5:0], code_b[11:6], entry_value[27:12], zero[31:28]
  input  logic        in_tuser,   // cmd[0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // pair_distance[31:0]
);
  import sps_pkg::*;

  lookup_t                   lk;
  logic signed [VALUE_W-1:0] penalty;
  logic                      advance;
  logic                      accept;

  assign accept = in_tvalid && in_tready;

  sps_table #(
    .ALPHABET(ALPHABET)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_tuser),
    .code_a      (in_tdata[5:0]),
    .code_b      (in_tdata[11:6]),
    .entry_value (in_tdata[27:12]),
    .last_feature(in_tlast),
    .advance     (advance),
    .ready       (in_tready),
    .lk          (lk),
    .penalty     (penalty)
  );

  sps_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .lk        (lk),
    .penalty   (penalty),
    .advance   (advance),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// ----- hdl/sps_table.sv -----
`timescale 1ns / 1ps

module sps_table #(
  parameter int ALPHABET = sps_pkg::ALPHABET_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic                               cmd,
  input  logic [sps_pkg::CODE_W-1:0]         code_a,
  input  logic [sps_pkg::CODE_W-1:0]         code_b,
  input  logic signed [sps_pkg::VALUE_W-1:0] entry_value,
  input  logic                               last_feature,
  input  logic                               advance,
  output logic                               ready,
  output sps_pkg::lookup_t                   lk,
  output logic signed [sps_pkg::VALUE_W-1:0] penalty
);
  import sps_pkg::*;

  localparam int DEPTH  = ALPHABET * ALPHABET;
  localparam int ADDR_W = $clog2(DEPTH);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  logic              valid_r, valid_nxt;
  logic              last_r;
  logic              ok_r;
  logic signed [VALUE_W-1:0] rd_r;
  logic              ok;
  logic [ADDR_W-1:0] addr;

  assign ok   = (int'(code_a) < ALPHABET) && (int'(code_b) < ALPHABET);
  assign addr = ADDR_W'(int'(code_a) * ALPHABET + int'(code_b));

  assign ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = accept && (cmd == CMD_PAIR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= last_feature;
      ok_r   <= ok;
    end
  end

  // table write on load, registered read on pair
  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_LOAD) && ok) begin
      mem[addr] <= entry_value;
    end
    if (accept && (cmd == CMD_PAIR)) begin
      rd_r <= mem[addr];
    end
  end

  assign lk.valid = valid_r;
  assign lk.last  = last_r;
  assign lk.ok    = ok_r;
  assign penalty  = rd_r;

endmodule

// ----- hdl/sps_accum.sv -----
`timescale 1ns / 1ps

module sps_accum (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sps_pkg::lookup_t                   lk,
  input  logic signed [sps_pkg::VALUE_W-1:0] penalty,
  output logic                               advance,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sps_pkg::SUM_W-1:0]          out_tdata
);
  import sps_pkg::*;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] dist_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W:0]   wide;
  logic signed [SUM_W-1:0] sat;
  logic signed [VALUE_W-1:0] add;
  logic                    slot_free;
  logic                    take;

  assign slot_free = !out_valid_r || out_tready;
  assign advance   = !(lk.valid && lk.last && !slot_free);
  assign take      = lk.valid && advance;

  always_comb begin
    add  = lk.ok ? penalty : '0;
    wide = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(add);
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sat = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat = wide[SUM_W-1:0];
    end
  end

  always_comb begin
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (take) begin
      sum_nxt = lk.last ? '0 : sat;
      if (lk.last) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && lk.last) begin
      dist_r <= sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dist_r;

endmodule

// ----- verif/substitution_penalty_sum_test.sv -----
`timescale 1ns / 1ps

module substitution_penalty_sum_test;
  import sps_pkg::*;

  typedef struct {
    logic        cmd;
    logic [5:0]  code_a;
    logic [5:0]  code_b;
    logic [15:0] value;
    logic        last;
    int          gap;
    bit          drain;
  } penalty_req_t;

  localparam int SAT_RUN = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  penalty_req_t             pending[$];
  penalty_req_t             offered;
  logic signed [31:0]       distance_expected[$];
  logic signed [15:0]       penalty_copy [0:4095];
  logic signed [31:0]       running_penalty = '0;
  bit                       written_map [0:4095];
  int                       written_list[$];
  bit                       drain_next = 1'b0;
  int                       idle_left = 0;
  int                       stall_left = 0;
  int                       results_seen = 0;
  bit                       held_off = 1'b0;
  int                       mismatches = 0;

  substitution_penalty_sum dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] random_penalty();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h7fff;
    if (r < 20) return 16'h8000;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void add_req(logic cmd, logic [5:0] a, logic [5:0] b, logic [15:0] v,
                                  logic last, int gap);
    penalty_req_t r;
    int idx;
    idx = int'({a, b});
    r.cmd = cmd;
    r.code_a = a;
    r.code_b = b;
    r.value = v;
    r.last = last;
    r.gap = gap;
    r.drain = drain_next;
    drain_next = 1'b0;
    pending.push_back(r);
    if (cmd == CMD_LOAD && !written_map[idx]) begin
      written_map[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endfunction

  function automatic void add_written_pair(logic last, int gap);
    int idx;
    idx = written_list[$urandom_range(0, written_list.size() - 1)];
    add_req(CMD_PAIR, idx[11:6], idx[5:0], 16'($urandom), last, gap);
  endfunction

  task automatic accumulate_penalty(input penalty_req_t r);
    longint s;
    if (r.cmd == CMD_LOAD) begin
      penalty_copy[{r.code_a, r.code_b}] = r.value;
    end else begin
      s = longint'(running_penalty) + longint'(penalty_copy[{r.code_a, r.code_b}]);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      if (r.last) begin
        distance_expected.push_back(s[31:0]);
        running_penalty = '0;
      end else begin
        running_penalty = s[31:0];
      end
    end
  endtask

  // driver: offer one request at a time, hold it until taken
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      idle_left = 0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        accumulate_penalty(offered);
        nv = 1'b0;
      end
      if (!nv) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && distance_expected.size() != 0)) begin
          offered = pending.pop_front();
          nv = 1'b1;
          idle_left = offered.gap;
          in_tdata <= {4'b0, offered.value, offered.code_b, offered.code_a};
          in_tuser <= offered.cmd;
          in_tlast <= offered.last;
        end
      end
      in_tvalid <= nv;
    end
  end

  // monitor: check each distance, then pick the next ready level
  always @(posedge clk) begin
    logic signed [31:0] exp_dist;
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (distance_expected.size() == 0) begin
          $display("%0t: unexpected pair_distance, expected none, got %0d",
                   $time, $signed(out_tdata));
          mismatches++;
        end else begin
          exp_dist = distance_expected.pop_front();
          if ($signed(out_tdata) !== exp_dist) begin
            $display("%0t: pair_distance mismatch, expected %0d, got %0d",
                     $time, exp_dist, $signed(out_tdata));
            mismatches++;
          end
        end
        results_seen++;
      end
      if (results_seen == 30 && !held_off) begin
        held_off = 1'b1;
        stall_left = 250;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ((results_seen / 25) % 4 == 1) begin
        out_tready <= 1'b1;
      end else begin
        g = idle_gap();
        if (g > 0) begin
          stall_left = g - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int n_random;
    int rec;
    int len;
    int r;
    int idx;
    int gap;
    bit quiet;
    bit drained_mid;

    n_random = 0;
    rec = 0;
    drained_mid = 1'b0;

    // table corners and bit patterns, last mark on a load
    add_req(CMD_LOAD, 6'd0, 6'd0, 16'h7fff, 1'b0, idle_gap());
    add_req(CMD_LOAD, 6'd63, 6'd63, 16'h8000, 1'b0, idle_gap());
    add_req(CMD_LOAD, 6'd0, 6'd63, 16'hffff, 1'b0, idle_gap());
    add_req(CMD_LOAD, 6'd63, 6'd0, 16'h0000, 1'b0, idle_gap());
    add_req(CMD_LOAD, 6'd42, 6'd21, 16'h5555, 1'b0, idle_gap());
    add_req(CMD_LOAD, 6'd21, 6'd42, 16'haaaa, 1'b1, idle_gap());
    add_req(CMD_PAIR, 6'd0, 6'd0, 16'h0000, 1'b1, idle_gap());
    add_req(CMD_PAIR, 6'd63, 6'd63, 16'hffff, 1'b1, idle_gap());
    add_req(CMD_PAIR, 6'd0, 6'd63, 16'h0000, 1'b0, idle_gap());
    add_req(CMD_PAIR, 6'd63, 6'd0, 16'h0000, 1'b0, idle_gap());
    add_req(CMD_PAIR, 6'd42, 6'd21, 16'h0000, 1'b1, idle_gap());
    add_req(CMD_PAIR, 6'd21, 6'd42, 16'hffff, 1'b1, idle_gap());
    add_req(CMD_PAIR, 6'd0, 6'd0, 16'h0000, 1'b0, idle_gap());
    add_req(CMD_PAIR, 6'd0, 6'd0, 16'h0000, 1'b0, idle_gap());
    add_req(CMD_PAIR, 6'd63, 6'd63, 16'h0000, 1'b1, idle_gap());
    add_req(CMD_PAIR, 6'd63, 6'd0, 16'h0000, 1'b1, idle_gap());
    add_req(CMD_LOAD, 6'd0, 6'd0, 16'h0001, 1'b0, 0);
    add_req(CMD_PAIR, 6'd0, 6'd0, 16'h0000, 1'b1, 0);
    add_req(CMD_LOAD, 6'd0, 6'd0, 16'h7fff, 1'b0, idle_gap());

    // long run at the largest penalty, then step back down
    for (int i = 0; i < SAT_RUN; i++) add_req(CMD_PAIR, 6'd0, 6'd0, 16'h0000, 1'b0, 0);
    add_req(CMD_PAIR, 6'd63, 6'd63, 16'h0000, 1'b1, 0);
    // long run at the smallest penalty, then step back up
    for (int i = 0; i < SAT_RUN; i++) add_req(CMD_PAIR, 6'd63, 6'd63, 16'h0000, 1'b0, 0);
    add_req(CMD_PAIR, 6'd0, 6'd0, 16'h0000, 1'b1, 0);

    drain_next = 1'b1;
    for (int i = 0; i < 40; i++) begin
      add_req(CMD_LOAD, 6'($urandom), 6'($urandom), random_penalty(), 1'($urandom), idle_gap());
      n_random++;
    end

    while (n_random < 650) begin
      quiet = (rec % 10 == 3) || (rec % 10 == 4);
      if (n_random > 400 && !drained_mid) begin
        drained_mid = 1'b1;
        drain_next = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 6);
      else if (r < 97) len = $urandom_range(7, 20);
      else len = 40;
      for (int k = 0; k < len; k++) begin
        gap = quiet ? 0 : idle_gap();
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 99) < 30)
            idx = written_list[$urandom_range(0, written_list.size() - 1)];
          else
            idx = $urandom_range(0, 4095);
          add_req(CMD_LOAD, idx[11:6], idx[5:0], random_penalty(), 1'($urandom), gap);
          n_random++;
        end
        add_written_pair(k == len - 1, quiet ? 0 : idle_gap());
        n_random++;
      end
      rec++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending.size() != 0 || in_tvalid);
    while (distance_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("substitution_penalty_sum verification clean");
    end else begin
      $display("substitution_penalty_sum verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("substitution_penalty_sum verification failed");
    $finish;
  end

endmodule
